[src/kvt_pkg.sv]
package kvt_pkg;

    localparam int CAPACITY   = 256;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int INDEX_W    = 8;
    localparam int LIMIT_W    = 9;
    localparam int LIMIT_RST  = 256;

    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_UPDATE = 3'd1,
        ACT_UPSERT = 3'd2,
        ACT_ERASE  = 3'd3,
        ACT_LOOKUP = 3'd4,
        ACT_READ   = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ERASE_RD,
        ST_ERASE_WR,
        ST_READ_RD,
        ST_READ_DONE,
        ST_RESP
    } t_state;

    typedef struct packed {
        t_action               action;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value_in;
        logic [INDEX_W-1:0]    entry_index;
    } t_req;

    typedef struct packed {
        logic                  ok;
        logic [VALUE_BITS-1:0] value_out;
        logic [KEY_BITS-1:0]   key_out;
        logic [CNT_W-1:0]      pair_count;
        logic                  is_empty;
    } t_rsp;

endpackage

[src/kvt_ram.sv]
module kvt_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/kvt_seq.sv]
module kvt_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    input  kvt_pkg::t_req i_req,
    input  logic          i_cfg_we,
    input  logic [kvt_pkg::LIMIT_W-1:0] i_cfg_data,
    output logic          o_rsp_valid,
    output kvt_pkg::t_rsp o_rsp,
    input  logic          i_rsp_take
);
    import kvt_pkg::*;

    t_state                r_state, n_state;
    t_req                  r_req, n_req;
    logic [CNT_W-1:0]      r_addr, n_addr;
    logic [ADDR_W-1:0]     r_prev, n_prev;
    logic                  r_rd_vld, n_rd_vld;
    logic [ADDR_W-1:0]     r_pos, n_pos;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [LIMIT_W-1:0]    r_cap;
    logic                  r_ok, n_ok;
    logic [VALUE_BITS-1:0] r_vout, n_vout;
    logic [KEY_BITS-1:0]   r_kout, n_kout;

    logic                  w_key_we, w_val_we;
    logic [ADDR_W-1:0]     w_waddr, w_raddr;
    logic [KEY_BITS-1:0]   w_wkey, w_rkey;
    logic [VALUE_BITS-1:0] w_wval, w_rval;
    logic [CNT_W-1:0]      w_limit;
    logic                  w_hit, w_miss, w_room, w_idx_ok;

    kvt_ram #(.DATA_W(KEY_BITS), .ADDR_W(ADDR_W)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wkey),
        .i_raddr (w_raddr),
        .o_rdata (w_rkey)
    );

    kvt_ram #(.DATA_W(VALUE_BITS), .ADDR_W(ADDR_W)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (w_val_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wval),
        .i_raddr (w_raddr),
        .o_rdata (w_rval)
    );

    // effective limit: configured value clamped to the storage depth
    assign w_limit  = (r_cap > LIMIT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(r_cap);
    assign w_room   = r_count < w_limit;
    assign w_hit    = r_rd_vld && (w_rkey == r_req.key);
    assign w_miss   = !r_rd_vld && (r_addr >= r_count);
    assign w_idx_ok = CNT_W'(r_req.entry_index) < r_count;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    case (i_req.action)
                        ACT_INSERT, ACT_UPDATE, ACT_UPSERT, ACT_ERASE, ACT_LOOKUP:
                            n_state = ST_SCAN;
                        ACT_READ: n_state = ST_READ_RD;
                        default:  n_state = ST_RESP;
                    endcase
                end
            end
            ST_SCAN: begin
                if (w_hit && r_req.action == ACT_ERASE) begin
                    n_state = ST_ERASE_RD;
                end else if (w_hit || w_miss) begin
                    n_state = ST_RESP;
                end
            end
            ST_ERASE_RD:  n_state = ST_ERASE_WR;
            ST_ERASE_WR:  n_state = ST_RESP;
            ST_READ_RD:   n_state = w_idx_ok ? ST_READ_DONE : ST_RESP;
            ST_READ_DONE: n_state = ST_RESP;
            ST_RESP: begin
                if (i_rsp_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_req    = r_req;
        n_addr   = r_addr;
        n_prev   = r_prev;
        n_rd_vld = 1'b0;
        n_pos    = r_pos;
        n_count  = r_count;
        n_ok     = r_ok;
        n_vout   = r_vout;
        n_kout   = r_kout;
        w_key_we = 1'b0;
        w_val_we = 1'b0;
        w_waddr  = r_prev;
        w_raddr  = r_addr[ADDR_W-1:0];
        w_wkey   = r_req.key;
        w_wval   = r_req.value_in;
        o_req_stall = 1'b1;
        o_rsp_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_req_stall = 1'b0;
                if (i_req_valid) begin
                    n_req  = i_req;
                    n_addr = '0;
                    n_ok   = 1'b0;
                    n_vout = '0;
                    n_kout = '0;
                end
            end
            ST_SCAN: begin
                // one key compare per cycle against the registered read data
                w_raddr  = r_addr[ADDR_W-1:0];
                n_rd_vld = r_addr < r_count;
                n_prev   = r_addr[ADDR_W-1:0];
                if (r_addr < r_count) begin
                    n_addr = r_addr + CNT_W'(1);
                end
                if (w_hit) begin
                    n_rd_vld = 1'b0;
                    case (r_req.action)
                        ACT_UPDATE, ACT_UPSERT: begin
                            w_val_we = 1'b1;
                            w_waddr  = r_prev;
                            n_ok     = 1'b1;
                        end
                        ACT_ERASE: n_pos = r_prev;
                        ACT_LOOKUP: begin
                            n_vout = w_rval;
                            n_ok   = 1'b1;
                        end
                        default: n_ok = 1'b0;
                    endcase
                end else if (w_miss) begin
                    if ((r_req.action == ACT_INSERT || r_req.action == ACT_UPSERT)
                        && w_room) begin
                        w_key_we = 1'b1;
                        w_val_we = 1'b1;
                        w_waddr  = r_count[ADDR_W-1:0];
                        n_count  = r_count + CNT_W'(1);
                        n_ok     = 1'b1;
                    end
                end
            end
            ST_ERASE_RD: begin
                w_raddr = ADDR_W'(r_count - CNT_W'(1));
            end
            ST_ERASE_WR: begin
                // last pair fills the hole
                w_key_we = 1'b1;
                w_val_we = 1'b1;
                w_waddr  = r_pos;
                w_wkey   = w_rkey;
                w_wval   = w_rval;
                n_count  = r_count - CNT_W'(1);
                n_ok     = 1'b1;
            end
            ST_READ_RD: begin
                w_raddr = r_req.entry_index[ADDR_W-1:0];
            end
            ST_READ_DONE: begin
                n_kout = w_rkey;
                n_vout = w_rval;
                n_ok   = 1'b1;
            end
            ST_RESP: begin
                o_rsp_valid = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_rsp.ok         = r_ok;
    assign o_rsp.value_out  = r_vout;
    assign o_rsp.key_out    = r_kout;
    assign o_rsp.pair_count = r_count;
    assign o_rsp.is_empty   = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_cap    <= LIMIT_W'(LIMIT_RST);
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= n_rd_vld;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_addr <= n_addr;
        r_prev <= n_prev;
        r_pos  <= n_pos;
        r_ok   <= n_ok;
        r_vout <= n_vout;
        r_kout <= n_kout;
    end

endmodule

[src/key_value_table.sv]
// Channel   Direction  Handshake                 Payload
// request   in         i_in_valid / o_in_stall   i_in_data  (t_req)
// result    out        o_out_valid / i_out_stall o_out_data (t_rsp)
// config    in         i_cfg_we                  i_cfg_data (capacity limit)
//
// Key search walks the key RAM one entry per cycle through its single read port;
// an erase that hits then reads the last pair and writes it into the freed slot.
// Read-by-index reads entry_index if below pair_count; unknown actions go straight to the result.
// A new request is taken once the result has moved into the output register.
// Reset is synchronous: count cleared, limit back to 256; table RAMs are not cleared.
module key_value_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  kvt_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output kvt_pkg::t_rsp o_out_data,
    input  logic          i_cfg_we,
    input  logic [kvt_pkg::LIMIT_W-1:0] i_cfg_data
);
    import kvt_pkg::*;

    logic r_out_vld;
    t_rsp r_out;
    logic w_rsp_valid;
    t_rsp w_rsp;
    logic w_take;

    kvt_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .o_req_stall (o_in_stall),
        .i_req       (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_rsp_valid (w_rsp_valid),
        .o_rsp       (w_rsp),
        .i_rsp_take  (w_take)
    );

    assign w_take = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_take) begin
            r_out_vld <= w_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_rsp_valid) begin
            r_out <= w_rsp;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

[src/kvt_checker.sv]
module kvt_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input kvt_pkg::t_rsp o_out_data
);
    import kvt_pkg::*;

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.is_empty == (o_out_data.pair_count == '0)))
        else $error("empty flag disagrees with count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.pair_count <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.ok |->
            o_out_data.key_out == '0 && o_out_data.value_out == '0)
        else $error("failed transaction carries data");

endmodule

bind key_value_table kvt_checker u_kvt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
